### sv/esdi_scl_pkg.sv
`default_nettype none

package esdi_scl_pkg;

  // Sector layout.
  localparam int unsigned ADDR_LEN     = 8;
  localparam int unsigned DATA_LEN     = 519;
  localparam int unsigned PAYLOAD_LEN  = 512;
  localparam int unsigned SECTOR_TOTAL = ADDR_LEN + DATA_LEN;
  localparam int unsigned POS_W        = $clog2(SECTOR_TOTAL + 1);

  // Queue between the front and back ends (power of two).
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] HDR_POLY = 16'h1021;
  localparam logic [47:0] DAT_POLY = 48'h1818_1450_3011;

  // Configuration register indexes, taken from paddr[2].
  localparam logic REG_HEAD_COUNT = 1'b0;
  localparam logic REG_SECT_TRACK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_ADDR = 2'd1,
    STATUS_BAD_DATA = 2'd2
  } status_e;

  // What the back end has to do with one byte.
  typedef enum logic [3:0] {
    KIND_ADDR_FIRST  = 4'd0,
    KIND_ADDR_CYL_HI = 4'd1,
    KIND_ADDR_CYL_LO = 4'd2,
    KIND_ADDR_HEAD   = 4'd3,
    KIND_ADDR_SECT   = 4'd4,
    KIND_ADDR_OTHER  = 4'd5,
    KIND_DATA        = 4'd6,
    KIND_DATA_PAY    = 4'd7,
    KIND_DATA_LAST   = 4'd8
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
  } scl_item_t;

  typedef struct packed {
    logic [7:0] head_count;
    logic [7:0] sectors_per_track;
  } scl_cfg_t;

  // MSB-first CRC-16 update with one byte.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ HDR_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // MSB-first CRC-48 update with one byte.
  function automatic logic [47:0] crc48_byte(logic [47:0] crc, logic [7:0] b);
    logic [47:0] c;
    c = crc ^ {b, 40'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[47] ? ({c[46:0], 1'b0} ^ DAT_POLY) : {c[46:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/esdi_scl_if.sv
`default_nettype none

interface esdi_scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       sector_start;

  modport source (output valid, output in_byte, output sector_start, input ready);
  modport sink   (input valid, input in_byte, input sector_start, output ready);
endinterface

interface esdi_scl_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] lba;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output out_byte, output lba, output status, output last,
                  input ready);
  modport sink   (input valid, input out_byte, input lba, input status, input last,
                  output ready);
endinterface

`default_nettype wire

### sv/esdi_scl_front.sv
`default_nettype none

module esdi_scl_front import esdi_scl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  esdi_scl_in_if.sink    in_ch,
  output     logic       push_valid_o,
  output     scl_item_t  push_item_o,
  input  wire logic      push_ready_i
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] pos_eff;
  logic             live;
  logic             accept;
  kind_e            kind;

  // A start mark restarts the sector at any time.
  assign pos_eff = in_ch.sector_start ? '0 : pos_q;
  assign live    = pos_eff < POS_W'(SECTOR_TOTAL);
  assign accept  = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = push_ready_i;
  assign push_valid_o = in_ch.valid && live;

  always_comb begin
    if (pos_eff == POS_W'(0)) begin
      kind = KIND_ADDR_FIRST;
    end else if (pos_eff == POS_W'(1)) begin
      kind = KIND_ADDR_CYL_HI;
    end else if (pos_eff == POS_W'(2)) begin
      kind = KIND_ADDR_CYL_LO;
    end else if (pos_eff == POS_W'(3)) begin
      kind = KIND_ADDR_HEAD;
    end else if (pos_eff == POS_W'(4)) begin
      kind = KIND_ADDR_SECT;
    end else if (pos_eff < POS_W'(ADDR_LEN)) begin
      kind = KIND_ADDR_OTHER;
    end else if (pos_eff == POS_W'(SECTOR_TOTAL - 1)) begin
      kind = KIND_DATA_LAST;
    end else if (pos_eff <= POS_W'(ADDR_LEN + PAYLOAD_LEN) && pos_eff != POS_W'(ADDR_LEN)) begin
      kind = KIND_DATA_PAY;
    end else begin
      kind = KIND_DATA;
    end
  end

  assign push_item_o.data = in_ch.in_byte;
  assign push_item_o.kind = kind;

  // Bytes past the end of a sector are taken and dropped.
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      pos_d = live ? pos_eff + POS_W'(1) : pos_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

### sv/esdi_scl_fifo.sv
`default_nettype none

module esdi_scl_fifo import esdi_scl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_valid_i,
  input  wire scl_item_t push_item_i,
  output     logic       push_ready_o,
  output     logic       pop_valid_o,
  output     scl_item_t  pop_item_o,
  input  wire logic      pop_ready_i
);

  scl_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + QCNT_W'(1);
      2'b01:   cnt_d = cnt_q - QCNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### sv/esdi_scl_back.sv
`default_nettype none

module esdi_scl_back import esdi_scl_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire scl_cfg_t  cfg_i,
  input  wire logic      q_valid_i,
  input  wire scl_item_t q_item_i,
  output     logic       q_ready_o,
  esdi_scl_out_if.source out_ch
);

  logic [15:0] hdr_crc_q, hdr_crc_d;
  logic [47:0] dat_crc_q, dat_crc_d;
  logic [15:0] cyl_q, cyl_d;
  logic [7:0]  head_q, head_d;
  logic [7:0]  sect_q, sect_d;

  // Product terms of the LBA, refreshed every cycle. Both the geometry and the
  // captured address settle long before the last byte of a sector.
  logic [15:0] hs_q;
  logic [15:0] head_prod_q;
  logic [31:0] cyl_prod_q;
  logic [31:0] lba;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [31:0] lba_q, lba_d;
  status_e     status_q, status_d;
  logic        last_q, last_d;

  logic        pop;
  logic [15:0] hdr_nxt;
  logic [47:0] dat_nxt;

  assign q_ready_o = !out_valid_q || out_ch.ready;
  assign pop       = q_valid_i && q_ready_o;
  assign hdr_nxt   = crc16_byte(hdr_crc_q, q_item_i.data);
  assign dat_nxt   = crc48_byte(dat_crc_q, q_item_i.data);
  assign lba       = cyl_prod_q + 32'(head_prod_q) + 32'(sect_q) - 32'd1;

  always_comb begin
    hdr_crc_d   = hdr_crc_q;
    dat_crc_d   = dat_crc_q;
    cyl_d       = cyl_q;
    head_d      = head_q;
    sect_d      = sect_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    out_byte_d  = out_byte_q;
    lba_d       = lba_q;
    status_d    = status_q;
    last_d      = last_q;
    if (pop) begin
      unique case (q_item_i.kind)
        KIND_ADDR_FIRST: begin
          hdr_crc_d = crc16_byte(16'h0000, q_item_i.data);
          dat_crc_d = '0;
        end
        KIND_ADDR_CYL_HI: begin
          hdr_crc_d = hdr_nxt;
          cyl_d     = {q_item_i.data, cyl_q[7:0]};
        end
        KIND_ADDR_CYL_LO: begin
          hdr_crc_d = hdr_nxt;
          cyl_d     = {cyl_q[15:8], q_item_i.data};
        end
        KIND_ADDR_HEAD: begin
          hdr_crc_d = hdr_nxt;
          head_d    = q_item_i.data;
        end
        KIND_ADDR_SECT: begin
          hdr_crc_d = hdr_nxt;
          sect_d    = q_item_i.data;
        end
        KIND_ADDR_OTHER: begin
          hdr_crc_d = hdr_nxt;
        end
        KIND_DATA: begin
          dat_crc_d = dat_nxt;
        end
        KIND_DATA_PAY: begin
          dat_crc_d   = dat_nxt;
          out_valid_d = 1'b1;
          out_byte_d  = q_item_i.data;
          lba_d       = '0;
          status_d    = STATUS_OK;
          last_d      = 1'b0;
        end
        KIND_DATA_LAST: begin
          dat_crc_d   = dat_nxt;
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          lba_d       = lba;
          last_d      = 1'b1;
          if (hdr_crc_q != '0) begin
            status_d = STATUS_BAD_ADDR;
          end else if (dat_nxt != '0) begin
            status_d = STATUS_BAD_DATA;
          end else begin
            status_d = STATUS_OK;
          end
        end
        default: begin
          hdr_crc_d = hdr_crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hdr_crc_q   <= '0;
      dat_crc_q   <= '0;
      cyl_q       <= '0;
      head_q      <= '0;
      sect_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      hdr_crc_q   <= hdr_crc_d;
      dat_crc_q   <= dat_crc_d;
      cyl_q       <= cyl_d;
      head_q      <= head_d;
      sect_q      <= sect_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    lba_q       <= lba_d;
    status_q    <= status_d;
    last_q      <= last_d;
    hs_q        <= 16'(cfg_i.head_count) * 16'(cfg_i.sectors_per_track);
    head_prod_q <= 16'(head_q) * 16'(cfg_i.sectors_per_track);
    cyl_prod_q  <= 32'(cyl_q) * 32'(hs_q);
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.lba      = lba_q;
  assign out_ch.status   = status_q;
  assign out_ch.last     = last_q;

endmodule

`default_nettype wire

### sv/esdi_sector_check_and_lba.sv
// Disk sector checker with LBA calculation.
//
// The in_ch channel takes one raw sector byte per item; sector_start marks the
// first byte of the address area and restarts the sector at any time. Each
// sector is 8 address bytes followed by 519 data bytes. The out_ch channel
// gives one item per payload byte (data bytes 1 to 512, last low), then one
// summary item with last high that carries the status and the LBA. Payload
// bytes are streamed before the data check, so the consumer must discard them
// when the summary status is not zero. Bytes after a finished sector without a
// start mark are taken and dropped.
//
// The block sustains one byte per cycle while out_ch does not stall. A byte
// taken from in_ch is written into the queue, then popped into the output
// register that drives out_ch. When out_ch stalls, the two-entry queue fills
// and in_ch.ready falls. Reset clears the position, the queue and the output
// valid flag and sets both geometry registers to 1. The geometry is written over
// the APB port at address 0 (head count) and 4 (sectors per track); the user
// must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module esdi_sector_check_and_lba import esdi_scl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  esdi_scl_in_if.sink      in_ch,
  esdi_scl_out_if.source   out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output     logic [31:0]  prdata,
  output     logic         pready
);

  scl_cfg_t  cfg_q;
  logic      cfg_we;

  logic      push_valid, push_ready;
  scl_item_t push_item;
  logic      pop_valid, pop_ready;
  scl_item_t pop_item;

  // The configuration port never inserts wait states.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_count        <= 8'd1;
      cfg_q.sectors_per_track <= 8'd1;
    end else if (cfg_we) begin
      if (paddr[2] == REG_HEAD_COUNT) begin
        cfg_q.head_count <= pwdata[7:0];
      end else begin
        cfg_q.sectors_per_track <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SECT_TRACK) begin
      prdata = {24'h0, cfg_q.sectors_per_track};
    end else begin
      prdata = {24'h0, cfg_q.head_count};
    end
  end

  // The front end tracks the byte position and tags each byte.
  esdi_scl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  esdi_scl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  // The back end runs both CRCs, captures the address and builds results.
  esdi_scl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_item_i  (pop_item),
    .q_ready_o (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
